[rtl/tcq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcq_pkg
// Shared types and constants for the two-class oldest-first queue.
// ----------------------------------------------------------------------------
package tcq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TAG_BITS_DEF    = 16;
    localparam int TAG_W           = 16;
    localparam int ORDER_W         = 32;
    localparam int FUNC_W          = 2;
    localparam int STATUS_W        = 2;

    typedef enum logic [FUNC_W-1:0] {
        FN_ENQ     = 2'd0,
        FN_DEQ_ANY = 2'd1,
        FN_DEQ_C0  = 2'd2,
        FN_DEQ_C1  = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic load_item;
        logic commit;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

[rtl/two_class_oldest_first_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// two_class_oldest_first_queue
// Two per-class FIFOs sharing one arrival counter; dequeue oldest first.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one request item: an
//   enqueue of a tagged item into its class queue, a dequeue of a named
//   class, or a dequeue of whichever class head arrived first.
//   Output channel (o_out_valid / i_out_ready) returns exactly one result
//   item per request: status, class, tag and arrival stamp.
//   A request is accepted only while the block is idle, so a new request waits
//   until the previous one has executed. The request is captured in
//   the idle state while the head entries are read from the class stores;
//   the execute state compares stamps, updates pointers and writes the store.
//   The result register decouples the sides: a new request is accepted while
//   an earlier result still waits. If the receiver stalls, the next request
//   holds in its execute state until the result register frees up.
//   Reset clears pointers, counts, the arrival counter and the result valid;
//   store contents are not cleared and are only read once written.
// ----------------------------------------------------------------------------
module two_class_oldest_first_queue #(
    parameter int QUEUE_DEPTH = tcq_pkg::QUEUE_DEPTH_DEF,
    parameter int TAG_BITS    = tcq_pkg::TAG_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [tcq_pkg::FUNC_W-1:0]    i_func,
    input  wire logic                          i_item_class,
    input  wire logic [tcq_pkg::TAG_W-1:0]     i_item_tag,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [tcq_pkg::STATUS_W-1:0]       o_status,
    output logic                               o_out_class,
    output logic [tcq_pkg::TAG_W-1:0]          o_out_tag,
    output logic [tcq_pkg::ORDER_W-1:0]        o_out_order
);
    import tcq_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequencer: idle -> execute -> idle
    tcq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // stores, pointers, stamp compare and result register
    tcq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_BITS    (TAG_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_func       (i_func),
        .i_item_class (i_item_class),
        .i_item_tag   (i_item_tag),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_out_class  (o_out_class),
        .o_out_tag    (o_out_tag),
        .o_out_order  (o_out_order)
    );

endmodule
`default_nettype wire

[rtl/tcq_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcq_ctrl
// Sequencer: take an item, then execute it once the output register is free.
// ----------------------------------------------------------------------------
module tcq_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire tcq_pkg::t_stat i_stat,
    output tcq_pkg::t_cmd       o_cmd
);
    import tcq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state        = r_state;
        o_cmd.load_item = 1'b0;
        o_cmd.commit    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_EXEC;
                end
            end
            S_EXEC: begin
                // hold until the result register can take the item's result
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

[rtl/tcq_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcq_datapath
// Class stores, head pointers, counts, arrival counter and result register.
// ----------------------------------------------------------------------------
module tcq_datapath #(
    parameter int QUEUE_DEPTH = tcq_pkg::QUEUE_DEPTH_DEF,
    parameter int TAG_BITS    = tcq_pkg::TAG_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire tcq_pkg::t_cmd                 i_cmd,
    output tcq_pkg::t_stat                     o_stat,
    input  wire logic [tcq_pkg::FUNC_W-1:0]    i_func,
    input  wire logic                          i_item_class,
    input  wire logic [tcq_pkg::TAG_W-1:0]     i_item_tag,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [tcq_pkg::STATUS_W-1:0]       o_status,
    output logic                               o_out_class,
    output logic [tcq_pkg::TAG_W-1:0]          o_out_tag,
    output logic [tcq_pkg::ORDER_W-1:0]        o_out_order
);
    import tcq_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = AW + 1;
    localparam int SB = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
    localparam int EW = SB + ORDER_W;

    // stores: {tag, stamp}
    logic [EW-1:0] r_mem0 [QUEUE_DEPTH];
    logic [EW-1:0] r_mem1 [QUEUE_DEPTH];
    logic [EW-1:0] r_rd0;
    logic [EW-1:0] r_rd1;

    logic [AW-1:0]      r_head0, r_head1;
    logic [CW-1:0]      r_count0, r_count1;
    logic [ORDER_W-1:0] r_arrival;

    logic [FUNC_W-1:0]  r_func;
    logic               r_class;
    logic [SB-1:0]      r_tag;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic                r_out_class;
    logic [TAG_W-1:0]    r_out_tag;
    logic [ORDER_W-1:0]  r_out_order;

    // execute-cycle decisions
    logic                n_status_v;
    logic [STATUS_W-1:0] n_status;
    logic                n_out_class;
    logic [TAG_W-1:0]    n_out_tag;
    logic [ORDER_W-1:0]  n_out_order;
    logic                do_push0, do_push1, do_pop0, do_pop1;
    logic [AW-1:0]       slot;
    logic [SW-1:0]       slot_sum;
    logic [AW-1:0]       tail_head;
    logic [CW-1:0]       tail_count;
    logic                tgt_full;
    logic                empty0, empty1;
    logic [ORDER_W-1:0]  stamp_diff;
    logic                pick1;
    logic [EW-1:0]       pick_entry;

    assign empty0     = (r_count0 == '0);
    assign empty1     = (r_count1 == '0);
    assign tail_head  = r_class ? r_head1 : r_head0;
    assign tail_count = r_class ? r_count1 : r_count0;
    assign tgt_full   = (tail_count == CW'(QUEUE_DEPTH));
    assign slot_sum   = SW'(tail_head) + SW'(tail_count);
    assign slot       = (slot_sum >= SW'(QUEUE_DEPTH)) ?
                        AW'(slot_sum - SW'(QUEUE_DEPTH)) : AW'(slot_sum);
    assign stamp_diff = r_rd0[ORDER_W-1:0] - r_rd1[ORDER_W-1:0];

    always_comb begin
        do_push0    = 1'b0;
        do_push1    = 1'b0;
        do_pop0     = 1'b0;
        do_pop1     = 1'b0;
        pick1       = 1'b0;
        n_status    = ST_DONE;
        n_out_class = 1'b0;
        n_out_tag   = '0;
        n_out_order = '0;
        n_status_v  = 1'b0;
        unique case (t_func'(r_func))
            FN_ENQ: begin
                if (tgt_full) begin
                    n_status = ST_FULL;
                end else begin
                    do_push0    = ~r_class;
                    do_push1    = r_class;
                    n_out_order = r_arrival;
                end
            end
            FN_DEQ_C0: begin
                do_pop0 = ~empty0;
            end
            FN_DEQ_C1: begin
                do_pop1 = ~empty1;
            end
            FN_DEQ_ANY: begin
                if (empty0) begin
                    do_pop1 = ~empty1;
                end else if (empty1) begin
                    do_pop0 = 1'b1;
                end else if (stamp_diff[ORDER_W-1]) begin
                    do_pop0 = 1'b1;
                end else begin
                    do_pop1 = 1'b1;
                end
            end
            default: n_status = ST_DONE;
        endcase
        if (r_func != FN_ENQ) begin
            pick1      = do_pop1;
            n_status_v = do_pop0 | do_pop1;
            if (!n_status_v) begin
                n_status = ST_EMPTY;
            end
        end
        pick_entry = pick1 ? r_rd1 : r_rd0;
        if (n_status_v) begin
            n_out_class         = pick1;
            n_out_tag[SB-1:0]   = pick_entry[EW-1:ORDER_W];
            n_out_order         = pick_entry[ORDER_W-1:0];
        end
    end

    assign o_stat.out_free = ~r_out_valid | i_out_ready;

    // capture the item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_func  <= i_func;
            r_class <= i_item_class;
            r_tag   <= i_item_tag[SB-1:0];
        end
    end

    // stores: write on commit, read heads every cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && do_push0) begin
            r_mem0[slot] <= {r_tag, r_arrival};
        end
        r_rd0 <= r_mem0[r_head0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && do_push1) begin
            r_mem1[slot] <= {r_tag, r_arrival};
        end
        r_rd1 <= r_mem1[r_head1];
    end

    // pointers, counts, arrival counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head0   <= '0;
            r_head1   <= '0;
            r_count0  <= '0;
            r_count1  <= '0;
            r_arrival <= '0;
        end else if (i_cmd.commit) begin
            if (do_push0) begin
                r_count0 <= r_count0 + CW'(1);
            end
            if (do_push1) begin
                r_count1 <= r_count1 + CW'(1);
            end
            if (do_push0 || do_push1) begin
                r_arrival <= r_arrival + ORDER_W'(1);
            end
            if (do_pop0) begin
                r_count0 <= r_count0 - CW'(1);
                r_head0  <= (r_head0 == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head0 + AW'(1);
            end
            if (do_pop1) begin
                r_count1 <= r_count1 - CW'(1);
                r_head1  <= (r_head1 == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head1 + AW'(1);
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status    <= n_status;
            r_out_class <= n_out_class;
            r_out_tag   <= n_out_tag;
            r_out_order <= n_out_order;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_out_class = r_out_class;
    assign o_out_tag   = r_out_tag;
    assign o_out_order = r_out_order;

endmodule
`default_nettype wire

[bench/two_class_oldest_first_queue_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_class_oldest_first_queue_tb
// Self-checking bench: pushes enqueue and dequeue requests through the queue,
// predicts every result with a behavioral copy of both class queues and the
// shared arrival counter, and compares each result item field by field
// while both channels idle and stall in several patterns.
// ----------------------------------------------------------------------------
module two_class_oldest_first_queue_tb;
    import tcq_pkg::*;

    localparam int DEPTH       = QUEUE_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 200;
    localparam int PHASE_ITEMS = 345;
    localparam int DRAIN_WAIT  = 8;

    // One result item as it leaves the block.
    typedef struct {
        t_status            status;
        logic               cls;
        logic [TAG_W-1:0]   tag;
        logic [ORDER_W-1:0] order;
    } result_t;

    // One stored entry of a class queue.
    typedef struct {
        logic [TAG_W-1:0]   tag;
        logic [ORDER_W-1:0] stamp;
    } entry_t;

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of both class queues and the arrival counter.
    // note_request advances the copy and queues the expected result;
    // check_result compares an observed result with the oldest one waiting.
    // ------------------------------------------------------------------------
    class arrival_scoreboard;
        entry_t             class0_fifo[$];
        entry_t             class1_fifo[$];
        logic [ORDER_W-1:0] next_stamp;
        result_t            expected_results[$];
        int                 errors;

        function new();
            next_stamp = '0;
            errors     = 0;
        endfunction

        // Pop the head of one class; empty status when that class holds nothing.
        function result_t pop_class(logic cls);
            result_t r;
            entry_t  e;
            r.status = ST_EMPTY;
            r.cls    = 1'b0;
            r.tag    = '0;
            r.order  = '0;
            if (cls && class1_fifo.size() != 0) begin
                e = class1_fifo.pop_front();
                r.status = ST_DONE;
                r.cls    = 1'b1;
                r.tag    = e.tag;
                r.order  = e.stamp;
            end else if (!cls && class0_fifo.size() != 0) begin
                e = class0_fifo.pop_front();
                r.status = ST_DONE;
                r.tag    = e.tag;
                r.order  = e.stamp;
            end
            return r;
        endfunction

        function result_t predict_request(t_func fn, logic cls, logic [TAG_W-1:0] tag);
            result_t            r;
            entry_t             e;
            logic [ORDER_W-1:0] age_diff;
            r.status = ST_DONE;
            r.cls    = 1'b0;
            r.tag    = '0;
            r.order  = '0;
            case (fn)
                FN_ENQ: begin
                    // A full class queue rejects the item; the counter holds.
                    if ((cls ? class1_fifo.size() : class0_fifo.size()) >= DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        e.tag   = tag;
                        e.stamp = next_stamp;
                        if (cls) begin
                            class1_fifo.push_back(e);
                        end else begin
                            class0_fifo.push_back(e);
                        end
                        r.order    = next_stamp;
                        next_stamp = next_stamp + 1'b1;
                    end
                end
                FN_DEQ_C0: r = pop_class(1'b0);
                FN_DEQ_C1: r = pop_class(1'b1);
                default: begin
                    if (class0_fifo.size() == 0) begin
                        r = pop_class(1'b1);
                    end else if (class1_fifo.size() == 0) begin
                        r = pop_class(1'b0);
                    end else begin
                        // Modular age compare: class 0 wins only when strictly
                        // older, so equal stamps go to class 1.
                        age_diff = class0_fifo[0].stamp - class1_fifo[0].stamp;
                        r = pop_class(~age_diff[ORDER_W-1]);
                    end
                end
            endcase
            return r;
        endfunction

        function void note_request(t_func fn, logic cls, logic [TAG_W-1:0] tag);
            expected_results.push_back(predict_request(fn, cls, tag));
        endfunction

        function void check_result(logic [STATUS_W-1:0] status, logic cls,
                                   logic [TAG_W-1:0] tag, logic [ORDER_W-1:0] order);
            result_t want;
            if (expected_results.size() == 0) begin
                $error("result item arrived with no request outstanding");
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if (status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, status);
                errors++;
            end
            if (cls !== want.cls) begin
                $error("out_class: expected %0d, got %0d", want.cls, cls);
                errors++;
            end
            if (tag !== want.tag) begin
                $error("out_tag: expected %h, got %h", want.tag, tag);
                errors++;
            end
            if (order !== want.order) begin
                $error("out_order: expected %0d, got %0d", want.order, order);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block inputs; every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                   i_clk        = 1'b0;
    logic                   i_rst_n      = 1'b0;
    logic                   i_in_valid   = 1'b0;
    logic [FUNC_W-1:0]      i_func       = FN_ENQ;
    logic                   i_item_class = 1'b0;
    logic [TAG_W-1:0]       i_item_tag   = '0;
    logic                   i_out_ready  = 1'b0;
    logic                   o_in_ready;
    logic                   o_out_valid;
    logic [STATUS_W-1:0]    o_status;
    logic                   o_out_class;
    logic [TAG_W-1:0]       o_out_tag;
    logic [ORDER_W-1:0]     o_out_order;

    arrival_scoreboard sb = new();

    // Idle and stall odds in percent per cycle; changed per phase.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    // Set by the stimulus to start one long receiver hold-off.
    bit hold_go        = 1'b0;
    int cycle_count    = 0;

    two_class_oldest_first_queue uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_func       (i_func),
        .i_item_class (i_item_class),
        .i_item_tag   (i_item_tag),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_out_class  (o_out_class),
        .o_out_tag    (o_out_tag),
        .o_out_order  (o_out_order)
    );

    // 8 ns period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Check every result item taken at a rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_status, o_out_class, o_out_tag, o_out_order);
        end
    end

    // Receiver: drive ready at the falling edge; random stalls, plus one long
    // hold-off counted here so the block backs up and stalls its input.
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_go) begin
                hold_go   = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Offer one request item; called at a falling edge, returns at the falling
    // edge after acceptance. Valid stays high across back-to-back items.
    task automatic send_request(t_func fn, logic cls, logic [TAG_W-1:0] tag);
        int gap;
        gap = 0;
        while (gap < 16 && $urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_func       <= fn;
        i_item_class <= cls;
        i_item_tag   <= tag;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(fn, cls, tag);
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        int               enq_pct;
        t_func            fn;
        logic             cls;
        logic [TAG_W-1:0] tag;
        enq_pct = 50;

        // Hold reset, release at a falling edge.
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: every dequeue on empty queues, extreme tags, oldest-first
        // pick between classes, then fill class 0 and overflow it.
        send_request(FN_DEQ_ANY, 1'b0, 16'h0000);
        send_request(FN_DEQ_C0,  1'b1, 16'hFFFF);
        send_request(FN_DEQ_C1,  1'b0, 16'h0000);
        send_request(FN_ENQ,     1'b1, 16'hFFFF);
        send_request(FN_ENQ,     1'b0, 16'h0000);
        send_request(FN_DEQ_ANY, 1'b1, 16'h1234);
        send_request(FN_DEQ_C0,  1'b0, 16'hFFFF);
        for (int i = 0; i < DEPTH; i++) begin
            send_request(FN_ENQ, 1'b0, TAG_W'(i * 16'h1111) ^ 16'hA5A5);
        end
        send_request(FN_ENQ, 1'b0, 16'hFFFF);

        // Random phases: no idling, sender idling, receiver stalling, both.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Swing the enqueue mix so the queues run full and dry in turn.
                if (n % 40 == 0) begin
                    case ($urandom_range(2))
                        0: enq_pct = 15;
                        1: enq_pct = 50;
                        default: enq_pct = 85;
                    endcase
                end
                // Start the long receiver hold-off while the sender keeps going.
                if (phase == 0 && n == 100) begin
                    hold_go = 1'b1;
                end
                if ($urandom_range(99) < enq_pct) begin
                    fn = FN_ENQ;
                end else begin
                    fn = t_func'($urandom_range(3, 1));
                end
                cls = 1'($urandom_range(1));
                case ($urandom_range(15))
                    0: tag = '0;
                    1: tag = '1;
                    default: tag = TAG_W'($urandom);
                endcase
                send_request(fn, cls, tag);
            end
        end
        i_in_valid <= 1'b0;

        // Drain, then wait for any stray result item.
        while (sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
